/* hdl/mrs_pkg.sv */
// Shared types, constants and CRC helper for the Modbus RTU slave engine.
// No dependencies; used by mrs_dp, mrs_ctrl and the top level.
`default_nettype none
package mrs_pkg;

  localparam int RX_DEPTH  = 256;
  localparam int RX_AW     = $clog2(RX_DEPTH);
  localparam int RX_CW     = RX_AW + 1;
  localparam int TX_DEPTH  = 256;
  localparam int TX_AW     = $clog2(TX_DEPTH);
  localparam int TX_CW     = TX_AW + 1;
  localparam int REG_DEPTH = 128;
  localparam int REG_AW    = $clog2(REG_DEPTH);

  localparam logic [7:0]  REGS_MAX = 8'(REG_DEPTH);
  localparam logic [15:0] MAX_QTY  = 16'd125;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  EXC_FLAG = 8'h80;

  // item kinds
  localparam logic [1:0] K_RX   = 2'd0;
  localparam logic [1:0] K_TICK = 2'd1;
  localparam logic [1:0] K_TX   = 2'd2;
  localparam logic [1:0] K_LWR  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE   = 2'd0;
  localparam logic [1:0] CFG_REGS    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  // frame status codes
  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_QUEUED = 3'd1;
  localparam logic [2:0] ST_BCAST  = 3'd2;
  localparam logic [2:0] ST_SHORT  = 3'd3;
  localparam logic [2:0] ST_OTHER  = 3'd4;
  localparam logic [2:0] ST_CRC    = 3'd5;
  localparam logic [2:0] ST_BUSY   = 3'd6;

  // function and exception codes
  localparam logic [7:0] FN_READ  = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h06;
  localparam logic [7:0] EXC_FN   = 8'h01;
  localparam logic [7:0] EXC_ADDR = 8'h02;
  localparam logic [7:0] EXC_VAL  = 8'h03;

  typedef enum logic [1:0] {
    RP_EXC  = 2'd0,
    RP_ECHO = 2'd1,
    RP_READ = 2'd2
  } reply_t;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_ACC  = 4'd1,
    OP_SCAN = 4'd2,
    OP_DEC  = 4'd3,
    OP_HDR  = 4'd4,
    OP_RRD  = 4'd5,
    OP_RHI  = 4'd6,
    OP_RLO  = 4'd7,
    OP_CLO  = 4'd8,
    OP_CHI  = 4'd9,
    OP_TXO  = 4'd10
  } op_t;

  typedef struct packed {
    logic go_scan;
    logic go_tx;
    logic scan_done;
    logic reply;
    logic hdr_done;
    logic rd_reply;
    logic reg_done;
    logic out_free;
  } dp_sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/mrs_in_if.sv */
// Input channel of the Modbus RTU slave engine: valid/ready plus item fields.
// No dependencies.
`default_nettype none
interface mrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  rx_byte;
  logic [6:0]  local_addr;
  logic [15:0] local_value;

  modport source (output valid, kind, rx_byte, local_addr, local_value, input ready);
  modport sink   (input valid, kind, rx_byte, local_addr, local_value, output ready);
endinterface
`default_nettype wire

/* hdl/mrs_out_if.sv */
// Result channel of the Modbus RTU slave engine: valid/ready plus result fields.
// No dependencies.
`default_nettype none
interface mrs_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic        drive_enable;
  logic        wrote_valid;
  logic [6:0]  wrote_addr;
  logic [15:0] wrote_value;
  logic [2:0]  frame_status;

  modport source (output valid, tx_valid, tx_byte, tx_last, drive_enable, wrote_valid,
                  wrote_addr, wrote_value, frame_status, input ready);
  modport sink   (input valid, tx_valid, tx_byte, tx_last, drive_enable, wrote_valid,
                  wrote_addr, wrote_value, frame_status, output ready);
endinterface
`default_nettype wire

/* hdl/mrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/mrs_dp.sv */
// Datapath: config registers, receive/holding/transmit stores, CRC, frame checks
// and result register. Depends on mrs_pkg and mrs_ram; driven by mrs_ctrl.
`default_nettype none
module mrs_dp import mrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  op_t         op,
  input  logic [1:0]  kind,
  input  logic [7:0]  rx_byte,
  input  logic [6:0]  local_addr,
  input  logic [15:0] local_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        out_ready,
  output dp_sts_t     sts,
  output logic        out_valid,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic        drive_enable,
  output logic        wrote_valid,
  output logic [6:0]  wrote_addr,
  output logic [15:0] wrote_value,
  output logic [2:0]  frame_status
);
  logic [7:0] slave_r, regcnt_r, tmo_r;

  logic [RX_CW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [7:0]       sil_r, sil_nxt;
  logic [RX_CW-1:0] scan_idx_r, scan_idx_nxt, rd_idx_r, rd_idx_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       hdr_r [6];
  logic [7:0]       hdr_nxt [6];
  logic [7:0]       rcrc_lo_r, rcrc_lo_nxt, rcrc_hi_r, rcrc_hi_nxt;

  reply_t           rtype_r, rtype_nxt;
  logic [7:0]       exc_r, exc_nxt;
  logic [REG_AW-1:0] reg_idx_r, reg_idx_nxt;
  logic [6:0]       qleft_r, qleft_nxt;
  logic [TX_CW-1:0] wptr_r, wptr_nxt;
  logic [TX_CW-1:0] tx_len_r, tx_len_nxt, tx_pos_r, tx_pos_nxt;
  logic [2:0]       fst_r, fst_nxt;
  logic             wv_r, wv_nxt;
  logic [6:0]       wa_r, wa_nxt;
  logic [15:0]      wd_r, wd_nxt;

  logic [REG_DEPTH-1:0] hv_r;
  logic                 hvd_r, hvd_nxt;

  logic        out_v_r, out_v_nxt;
  logic        o_txv_r, o_txl_r, o_de_r, o_wv_r;
  logic [7:0]  o_txb_r;
  logic [6:0]  o_wa_r;
  logic [15:0] o_wd_r;
  logic [2:0]  o_st_r;
  logic        o_txv, o_txl, o_de, o_wv;
  logic [7:0]  o_txb;
  logic [6:0]  o_wa;
  logic [15:0] o_wd;
  logic [2:0]  o_st;
  logic        ld;

  logic              rx_we;
  logic [7:0]        rx_rdata;
  logic              hold_we;
  logic [REG_AW-1:0] hold_waddr;
  logic [15:0]       hold_wdata, hold_rdata, hdata;
  logic              tx_we;
  logic [7:0]        tx_wdata, tx_rdata;

  logic [7:0]  sil_inc;
  logic        end_frame, busy, go_scan, issue;
  logic [15:0] a, q;
  logic [7:0]  regs, hbyte;
  logic        d_other, d_crcbad, d_bcast, d_reply, d_wr, short8;
  reply_t      d_rtype;
  logic [7:0]  d_exc;
  logic [2:0]  d_status;

  mrs_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_cnt_r[RX_AW-1:0]), .wdata(rx_byte),
    .raddr(scan_idx_r[RX_AW-1:0]), .rdata(rx_rdata)
  );

  mrs_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_hold_ram (
    .clk(clk), .we(hold_we), .waddr(hold_waddr), .wdata(hold_wdata),
    .raddr(reg_idx_r), .rdata(hold_rdata)
  );

  mrs_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(wptr_r[TX_AW-1:0]), .wdata(tx_wdata),
    .raddr(tx_pos_r[TX_AW-1:0]), .rdata(tx_rdata)
  );

  // frame decision, valid only after the scan
  always_comb begin
    a        = {hdr_r[2], hdr_r[3]};
    q        = {hdr_r[4], hdr_r[5]};
    regs     = (regcnt_r > REGS_MAX) ? REGS_MAX : regcnt_r;
    short8   = rx_cnt_r < RX_CW'(8);
    d_bcast  = hdr_r[0] == 8'h00;
    d_other  = !d_bcast && (hdr_r[0] != slave_r);
    d_crcbad = {rcrc_hi_r, rcrc_lo_r} != crc_r;
    d_reply  = 1'b0;
    d_wr     = 1'b0;
    d_rtype  = RP_EXC;
    d_exc    = EXC_FN;
    if (!d_other && !d_crcbad) begin
      if (hdr_r[1] == FN_READ) begin
        d_reply = !d_bcast;
        if (short8 || q == 16'd0 || q > MAX_QTY) begin
          d_exc = EXC_VAL;
        end else if (({1'b0, a} + {1'b0, q}) > {9'd0, regs}) begin
          d_exc = EXC_ADDR;
        end else begin
          d_rtype = RP_READ;
        end
      end else if (hdr_r[1] == FN_WRITE) begin
        d_reply = !d_bcast;
        if (short8) begin
          d_exc = EXC_VAL;
        end else if (a >= {8'd0, regs}) begin
          d_exc = EXC_ADDR;
        end else begin
          d_wr    = 1'b1;
          d_rtype = RP_ECHO;
        end
      end else begin
        d_reply = !d_bcast;
      end
    end
    priority if (d_other) d_status = ST_OTHER;
    else if (d_crcbad)    d_status = ST_CRC;
    else if (d_bcast)     d_status = ST_BCAST;
    else                  d_status = ST_QUEUED;
  end

  // reply header byte at the current write position
  always_comb begin
    unique case (wptr_r[2:0])
      3'd0: hbyte = slave_r;
      3'd1: hbyte = (rtype_r == RP_EXC) ? (hdr_r[1] | EXC_FLAG) : hdr_r[1];
      3'd2: begin
        priority if (rtype_r == RP_EXC) hbyte = exc_r;
        else if (rtype_r == RP_READ)    hbyte = {hdr_r[5][6:0], 1'b0};
        else                            hbyte = hdr_r[2];
      end
      3'd3: hbyte = hdr_r[3];
      3'd4: hbyte = hdr_r[4];
      default: hbyte = hdr_r[5];
    endcase
  end

  assign hdata = hvd_r ? hold_rdata : 16'h0000;

  always_comb begin
    rx_cnt_nxt = rx_cnt_r;  sil_nxt = sil_r;
    scan_idx_nxt = scan_idx_r;  rd_idx_nxt = rd_idx_r;  rd_v_nxt = rd_v_r;
    crc_nxt = crc_r;  hdr_nxt = hdr_r;
    rcrc_lo_nxt = rcrc_lo_r;  rcrc_hi_nxt = rcrc_hi_r;
    rtype_nxt = rtype_r;  exc_nxt = exc_r;  reg_idx_nxt = reg_idx_r;  qleft_nxt = qleft_r;
    wptr_nxt = wptr_r;  tx_len_nxt = tx_len_r;  tx_pos_nxt = tx_pos_r;
    fst_nxt = fst_r;  wv_nxt = wv_r;  wa_nxt = wa_r;  wd_nxt = wd_r;
    hvd_nxt = hvd_r;
    rx_we = 1'b0;  hold_we = 1'b0;  tx_we = 1'b0;
    hold_waddr = local_addr[REG_AW-1:0];  hold_wdata = local_value;  tx_wdata = 8'h00;
    ld = 1'b0;
    o_txv = 1'b0;  o_txb = 8'h00;  o_txl = 1'b0;
    o_wv = 1'b0;  o_wa = 7'd0;  o_wd = 16'h0000;  o_st = ST_NONE;

    sil_inc   = (sil_r == 8'hFF) ? sil_r : sil_r + 8'd1;
    end_frame = (rx_cnt_r != '0) && (sil_inc >= tmo_r);
    busy      = tx_pos_r < tx_len_r;
    go_scan   = (kind == K_TICK) && end_frame && !busy && (rx_cnt_r >= RX_CW'(4));
    issue     = scan_idx_r < rx_cnt_r;

    unique case (op)
      OP_NONE: ;
      OP_ACC: begin
        unique case (kind)
          K_RX: begin
            if (!rx_cnt_r[RX_CW-1]) begin
              rx_we      = 1'b1;
              rx_cnt_nxt = rx_cnt_r + 1'b1;
              sil_nxt    = 8'd0;
            end
            ld = 1'b1;
          end
          K_TICK: begin
            ld = !go_scan;
            if (rx_cnt_r != '0) begin
              sil_nxt = sil_inc;
              if (end_frame) begin
                if (busy || rx_cnt_r < RX_CW'(4)) begin
                  o_st       = busy ? ST_BUSY : ST_SHORT;
                  rx_cnt_nxt = '0;
                  sil_nxt    = 8'd0;
                end else begin
                  scan_idx_nxt = '0;
                  rd_v_nxt     = 1'b0;
                  crc_nxt      = CRC_INIT;
                end
              end
            end
          end
          K_TX: ld = !busy;
          default: begin
            hold_we = 1'b1;
            ld      = 1'b1;
          end
        endcase
      end
      OP_SCAN: begin
        if (issue) scan_idx_nxt = scan_idx_r + 1'b1;
        rd_v_nxt   = issue;
        rd_idx_nxt = scan_idx_r;
        if (rd_v_r) begin
          if (rd_idx_r < rx_cnt_r - RX_CW'(2)) crc_nxt = crc_byte(crc_r, rx_rdata);
          if (rd_idx_r < RX_CW'(6)) hdr_nxt[rd_idx_r[2:0]] = rx_rdata;
          if (rd_idx_r == rx_cnt_r - RX_CW'(2)) rcrc_lo_nxt = rx_rdata;
          if (rd_idx_r == rx_cnt_r - RX_CW'(1)) rcrc_hi_nxt = rx_rdata;
        end
      end
      OP_DEC: begin
        rtype_nxt   = d_rtype;
        exc_nxt     = d_exc;
        reg_idx_nxt = a[REG_AW-1:0];
        qleft_nxt   = q[6:0];
        wptr_nxt    = '0;
        crc_nxt     = CRC_INIT;
        rx_cnt_nxt  = '0;
        sil_nxt     = 8'd0;
        fst_nxt     = d_status;
        wv_nxt      = d_wr;
        wa_nxt      = d_wr ? a[6:0] : 7'd0;
        wd_nxt      = d_wr ? q : 16'h0000;
        if (d_wr) begin
          hold_we    = 1'b1;
          hold_waddr = a[REG_AW-1:0];
          hold_wdata = q;
        end
        if (!d_reply) begin
          ld   = 1'b1;
          o_st = d_status;
          o_wv = d_wr;
          o_wa = d_wr ? a[6:0] : 7'd0;
          o_wd = d_wr ? q : 16'h0000;
        end
      end
      OP_HDR: begin
        tx_we    = 1'b1;
        tx_wdata = hbyte;
        crc_nxt  = crc_byte(crc_r, hbyte);
        wptr_nxt = wptr_r + 1'b1;
      end
      OP_RRD: hvd_nxt = hv_r[reg_idx_r];
      OP_RHI: begin
        tx_we    = 1'b1;
        tx_wdata = hdata[15:8];
        crc_nxt  = crc_byte(crc_r, hdata[15:8]);
        wptr_nxt = wptr_r + 1'b1;
      end
      OP_RLO: begin
        tx_we       = 1'b1;
        tx_wdata    = hdata[7:0];
        crc_nxt     = crc_byte(crc_r, hdata[7:0]);
        wptr_nxt    = wptr_r + 1'b1;
        reg_idx_nxt = reg_idx_r + 1'b1;
        qleft_nxt   = qleft_r - 7'd1;
      end
      OP_CLO: begin
        tx_we    = 1'b1;
        tx_wdata = crc_r[7:0];
        wptr_nxt = wptr_r + 1'b1;
      end
      OP_CHI: begin
        tx_we      = 1'b1;
        tx_wdata   = crc_r[15:8];
        tx_len_nxt = wptr_r + 1'b1;
        tx_pos_nxt = '0;
        ld         = 1'b1;
        o_st       = fst_r;
        o_wv       = wv_r;
        o_wa       = wa_r;
        o_wd       = wd_r;
      end
      default: begin
        ld         = 1'b1;
        o_txv      = 1'b1;
        o_txb      = tx_rdata;
        tx_pos_nxt = tx_pos_r + 1'b1;
        o_txl      = (tx_pos_r + 1'b1) == tx_len_r;
      end
    endcase

    o_de      = o_txv || (tx_pos_nxt < tx_len_nxt);
    out_v_nxt = ld || (out_v_r && !out_ready);

    sts.go_scan   = go_scan;
    sts.go_tx     = (kind == K_TX) && busy;
    sts.scan_done = !issue && !rd_v_r;
    sts.reply     = d_reply;
    sts.hdr_done  = wptr_r == ((rtype_r == RP_ECHO) ? TX_CW'(5) : TX_CW'(2));
    sts.rd_reply  = rtype_r == RP_READ;
    sts.reg_done  = qleft_r == 7'd1;
    sts.out_free  = !out_v_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r  <= 8'd1;
      regcnt_r <= REGS_MAX;
      tmo_r    <= 8'd4;
      rx_cnt_r <= '0;
      sil_r    <= 8'd0;
      tx_len_r <= '0;
      tx_pos_r <= '0;
      rd_v_r   <= 1'b0;
      hv_r     <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLAVE:   slave_r  <= cfg_wdata;
          CFG_REGS:    regcnt_r <= cfg_wdata;
          CFG_TIMEOUT: tmo_r    <= cfg_wdata;
          default: ;
        endcase
      end
      rx_cnt_r <= rx_cnt_nxt;
      sil_r    <= sil_nxt;
      tx_len_r <= tx_len_nxt;
      tx_pos_r <= tx_pos_nxt;
      rd_v_r   <= rd_v_nxt;
      if (hold_we) hv_r[hold_waddr] <= 1'b1;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    crc_r      <= crc_nxt;
    hdr_r      <= hdr_nxt;
    rcrc_lo_r  <= rcrc_lo_nxt;
    rcrc_hi_r  <= rcrc_hi_nxt;
    rtype_r    <= rtype_nxt;
    exc_r      <= exc_nxt;
    reg_idx_r  <= reg_idx_nxt;
    qleft_r    <= qleft_nxt;
    wptr_r     <= wptr_nxt;
    fst_r      <= fst_nxt;
    wv_r       <= wv_nxt;
    wa_r       <= wa_nxt;
    wd_r       <= wd_nxt;
    hvd_r      <= hvd_nxt;
    if (ld) begin
      o_txv_r <= o_txv;
      o_txb_r <= o_txb;
      o_txl_r <= o_txl;
      o_de_r  <= o_de;
      o_wv_r  <= o_wv;
      o_wa_r  <= o_wa;
      o_wd_r  <= o_wd;
      o_st_r  <= o_st;
    end
  end

  assign out_valid    = out_v_r;
  assign tx_valid     = o_txv_r;
  assign tx_byte      = o_txb_r;
  assign tx_last      = o_txl_r;
  assign drive_enable = o_de_r;
  assign wrote_valid  = o_wv_r;
  assign wrote_addr   = o_wa_r;
  assign wrote_value  = o_wd_r;
  assign frame_status = o_st_r;

`ifndef SYNTHESIS
  a_pos_le_len: assert property (@(posedge clk) disable iff (!rst_n) tx_pos_r <= tx_len_r)
    else $error("transmit position ran past reply length");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> (!out_v_r || out_ready))
    else $error("result register overwritten while held");
  a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_cnt_r <= RX_CW'(RX_DEPTH))
    else $error("receive count beyond store depth");
  a_tx_len_fit: assert property (@(posedge clk) disable iff (!rst_n)
    tx_len_r <= TX_CW'(TX_DEPTH))
    else $error("reply longer than transmit store");
`endif
endmodule
`default_nettype wire

/* hdl/mrs_ctrl.sv */
// Control state machine: sequences accept, frame scan, decision, reply build
// and transmit reads. Depends on mrs_pkg; commands mrs_dp.
`default_nettype none
module mrs_ctrl import mrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output op_t     op
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_SCAN = 10'b00_0000_0010,
    S_DEC  = 10'b00_0000_0100,
    S_HDR  = 10'b00_0000_1000,
    S_RRD  = 10'b00_0001_0000,
    S_RHI  = 10'b00_0010_0000,
    S_RLO  = 10'b00_0100_0000,
    S_CLO  = 10'b00_1000_0000,
    S_CHI  = 10'b01_0000_0000,
    S_TXO  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign acc      = in_ready && in_valid;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          op = OP_ACC;
          priority if (sts.go_scan) state_nxt = S_SCAN;
          else if (sts.go_tx)       state_nxt = S_TXO;
          else                      state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (sts.scan_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        op        = OP_DEC;
        state_nxt = sts.reply ? S_HDR : S_IDLE;
      end
      S_HDR: begin
        op = OP_HDR;
        if (sts.hdr_done) state_nxt = sts.rd_reply ? S_RRD : S_CLO;
      end
      S_RRD: begin
        op        = OP_RRD;
        state_nxt = S_RHI;
      end
      S_RHI: begin
        op        = OP_RHI;
        state_nxt = S_RLO;
      end
      S_RLO: begin
        op        = OP_RLO;
        state_nxt = sts.reg_done ? S_CLO : S_RRD;
      end
      S_CLO: begin
        op        = OP_CLO;
        state_nxt = S_CHI;
      end
      S_CHI: begin
        op        = OP_CHI;
        state_nxt = S_IDLE;
      end
      S_TXO: begin
        op        = OP_TXO;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHI || state_r == S_TXO) |-> sts.out_free)
    else $error("result register busy at end of a multi-cycle item");
  a_scan_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && $past(state_r) == S_IDLE) |-> $past(acc))
    else $error("scan started without an accepted item");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input taken while an item is in progress");
`endif
endmodule
`default_nettype wire

/* hdl/modbus_rtu_slave_engine.sv */
// Modbus RTU slave engine. Byte, tick and local-write items are handled when accepted;
// a transmit slot also reads the transmit store. A tick that ends a frame scans
// the received bytes through the receive store, then writes the header bytes,
// each register read (holding store, high byte, low byte) and the CRC bytes.
// Results leave through an output register. Synchronous active-low reset
// clears counters and holding-register valid bits and sets config to defaults; no clearing pass.
`default_nettype none
module modbus_rtu_slave_engine import mrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mrs_in_if.sink    in_ch,
  mrs_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  dp_sts_t sts;
  op_t     op;

  mrs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .op(op)
  );

  mrs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .op(op),
    .kind(in_ch.kind), .rx_byte(in_ch.rx_byte),
    .local_addr(in_ch.local_addr), .local_value(in_ch.local_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_ready(out_ch.ready), .sts(sts), .out_valid(out_ch.valid),
    .tx_valid(out_ch.tx_valid), .tx_byte(out_ch.tx_byte), .tx_last(out_ch.tx_last),
    .drive_enable(out_ch.drive_enable), .wrote_valid(out_ch.wrote_valid),
    .wrote_addr(out_ch.wrote_addr), .wrote_value(out_ch.wrote_value),
    .frame_status(out_ch.frame_status)
  );
endmodule
`default_nettype wire
